// ----- src/strps_pkg.sv -----
// Shared types and constants for the short-term reference picture set parser.
package strps_pkg;

  // Result error codes
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_REF  = 2'd1,
    ERR_POSITIVE = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_code_t;

  // Input opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_BIT   = 1'b1;

  // Fixed field widths
  localparam int SET_IDX_W = 7;
  localparam int ENTRY_W   = 4;
  localparam int POC_W     = 16;
  localparam int GVAL_W    = 33;
  localparam int GZERO_W   = 6;

  // Longest Exp-Golomb prefix accepted
  localparam logic [GZERO_W-1:0] GOLOMB_MAX_ZEROS = 6'd32;
  // Largest coded value (delta magnitude minus one) a delta may take
  localparam logic [GVAL_W-1:0] POC_MAG_MAX = 33'd32767;

endpackage

// ----- src/strps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module strps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/short_term_ref_pic_set_parser.sv -----
// Top level of the short-term reference picture set parser.
//
// A start transaction (opcode 0) names a set; the set's header bits then
// follow one per transaction, and each bit is consumed by a small sequencer
// around a shared Exp-Golomb decoder. When the last bit of an
// inter-predicted set arrives, the block walks the reference row of the set
// table, reading and shifting each reference entry and writing the derived
// entries; it then reads the finished row back one result at a time,
// holding each through any output stall. During the walk and while results
// are pending in_ready is low. Errors and empty sets give a single result
// with entry_valid low. Starting a set clears its count; reset does not.
module short_term_ref_pic_set_parser
  import strps_pkg::*;
#(
  parameter int MAX_SETS = 64,
  parameter int MAX_PICS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [SET_IDX_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_opcode,
  input  logic [SET_IDX_W-1:0] in_set_index,
  input  logic                 in_bit_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SET_IDX_W-1:0] out_out_set,
  output logic [ENTRY_W-1:0]   out_entry_index,
  output logic signed [POC_W-1:0] out_delta_poc,
  output logic                 out_used_by_current,
  output logic                 out_entry_valid,
  output logic [1:0]           out_error_code,
  output logic                 out_last
);

  localparam int SET_W = (MAX_SETS + 1 > 1) ? $clog2(MAX_SETS + 1) : 1;
  localparam int PIC_W = (MAX_PICS > 1) ? $clog2(MAX_PICS) : 1;
  localparam int CNT_W = $clog2(MAX_PICS + 1);
  localparam int TAB_AW = SET_W + PIC_W;
  localparam int TAB_DEPTH = (MAX_SETS + 1) << PIC_W;
  localparam logic [SET_IDX_W-1:0] MAX_SET_IDX = SET_IDX_W'(MAX_SETS);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PICS);

  typedef enum logic [4:0] {
    S_IDLE, S_INTER_FLAG, S_DELTA_IDX, S_SIGN, S_ABS_DELTA, S_USED_FLAG,
    S_DELTA_FLAG, S_NUM_NEG, S_NUM_POS, S_POC_DELTA, S_POC_USED,
    S_DER_FIRST, S_DER_RD, S_DER_CALC, S_EMIT_RD, S_EMIT_LD, S_EMIT_HOLD,
    S_OUT_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic [SET_IDX_W-1:0] num_sets_r;
  logic [SET_IDX_W-1:0] cur_set_r, cur_set_nxt;
  logic [SET_IDX_W-1:0] ref_set_r, ref_set_nxt;
  logic [CNT_W-1:0] target_r, target_nxt;
  logic [CNT_W-1:0] loop_r, loop_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic signed [16:0] delta_rps_r, delta_rps_nxt;
  logic signed [16:0] run_poc_r, run_poc_nxt;
  logic sign_r, sign_nxt;
  logic [GZERO_W-1:0] g_zeros_r, g_zeros_nxt;
  logic [GVAL_W-1:0] g_val_r, g_val_nxt;
  logic g_suf_r, g_suf_nxt;
  logic [MAX_PICS:0] sfu_r, sfu_nxt;
  logic [MAX_PICS:0] sdf_r, sdf_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [SET_IDX_W-1:0] o_set_r, o_set_nxt;
  logic [ENTRY_W-1:0] o_idx_r, o_idx_nxt;
  logic [POC_W-1:0] o_poc_r, o_poc_nxt;
  logic o_used_r, o_used_nxt, o_ev_r, o_ev_nxt, o_last_r, o_last_nxt;
  logic [1:0] o_err_r, o_err_nxt;

  // Table and count store ports
  logic tw_en;
  logic [TAB_AW-1:0] tw_addr, tr_addr;
  logic [POC_W:0] tw_data, tr_data;
  logic cw_en;
  logic [SET_W-1:0] cw_addr;
  logic [CNT_W-1:0] cw_data, cr_data;

  // Exp-Golomb step results
  logic g_done, g_ovf;
  logic [GVAL_W-1:0] g_res, g_shift;
  logic [GZERO_W-1:0] gz_step;
  logic [GVAL_W-1:0] gv_step;
  logic gs_step;

  logic in_acc, bit_in;
  logic signed [17:0] d_calc, p_calc;
  logic [CNT_W:0] loop_inc;

  assign in_acc = in_valid && in_ready;
  assign bit_in = in_bit_value;
  assign loop_inc = {1'b0, loop_r} + 1'b1;

  strps_ram #(.WIDTH(POC_W + 1), .DEPTH(TAB_DEPTH)) u_tab (
    .clk(clk), .we(tw_en), .waddr(tw_addr), .wdata(tw_data),
    .raddr(tr_addr), .rdata(tr_data)
  );

  strps_ram #(.WIDTH(CNT_W), .DEPTH(MAX_SETS + 1)) u_cnt (
    .clk(clk), .we(cw_en), .waddr(cw_addr), .wdata(cw_data),
    .raddr(ref_set_r[SET_W-1:0]), .rdata(cr_data)
  );

  // Decode one Exp-Golomb bit
  always_comb begin
    g_done = 1'b0;
    g_ovf = 1'b0;
    g_res = '0;
    gz_step = g_zeros_r;
    gv_step = g_val_r;
    gs_step = g_suf_r;
    g_shift = {g_val_r[GVAL_W-2:0], bit_in};
    if (!g_suf_r) begin
      if (!bit_in) begin
        gz_step = g_zeros_r + 1'b1;
        g_ovf = (g_zeros_r == GOLOMB_MAX_ZEROS);
      end else if (g_zeros_r == '0) begin
        g_done = 1'b1;
      end else begin
        gv_step = GVAL_W'(1);
        gs_step = 1'b1;
      end
    end else begin
      gv_step = g_shift;
      gz_step = g_zeros_r - 1'b1;
      if (g_zeros_r == GZERO_W'(1)) begin
        g_done = 1'b1;
        g_res = g_shift - 1'b1;
        gs_step = 1'b0;
      end
    end
  end

  assign d_calc = 18'(signed'(tr_data[POC_W-1:0])) + 18'(delta_rps_r);
  assign p_calc = 18'(run_poc_r) - signed'({2'b00, g_res[POC_W-1:0]}) - 18'sd1;

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    cur_set_nxt = cur_set_r;
    ref_set_nxt = ref_set_r;
    target_nxt = target_r;
    loop_nxt = loop_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    delta_rps_nxt = delta_rps_r;
    run_poc_nxt = run_poc_r;
    sign_nxt = sign_r;
    g_zeros_nxt = g_zeros_r;
    g_val_nxt = g_val_r;
    g_suf_nxt = g_suf_r;
    sfu_nxt = sfu_r;
    sdf_nxt = sdf_r;
    out_valid_nxt = out_valid_r;
    o_set_nxt = o_set_r;
    o_idx_nxt = o_idx_r;
    o_poc_nxt = o_poc_r;
    o_used_nxt = o_used_r;
    o_ev_nxt = o_ev_r;
    o_last_nxt = o_last_r;
    o_err_nxt = o_err_r;
    tw_en = 1'b0;
    tw_addr = {cur_set_r[SET_W-1:0], loop_r[PIC_W-1:0]};
    tw_data = {bit_in, run_poc_r[POC_W-1:0]};
    tr_addr = {cur_set_r[SET_W-1:0], idx_r[PIC_W-1:0]};
    cw_en = 1'b0;
    cw_addr = cur_set_r[SET_W-1:0];
    cw_data = '0;

    // Golomb-coded phases advance the decoder on every bit
    if (in_acc && in_opcode == OP_BIT &&
        (state_r == S_DELTA_IDX || state_r == S_ABS_DELTA ||
         state_r == S_NUM_NEG || state_r == S_NUM_POS ||
         state_r == S_POC_DELTA)) begin
      g_zeros_nxt = gz_step;
      g_val_nxt = gv_step;
      g_suf_nxt = gs_step;
    end

    if (in_acc && in_opcode == OP_START) begin
      // Start a set, abandoning any set in progress
      cur_set_nxt = in_set_index;
      g_zeros_nxt = '0;
      g_val_nxt = '0;
      g_suf_nxt = 1'b0;
      if (in_set_index > MAX_SET_IDX) begin
        out_valid_nxt = 1'b1;
        o_set_nxt = in_set_index;
        o_idx_nxt = '0;
        o_poc_nxt = '0;
        o_used_nxt = 1'b0;
        o_ev_nxt = 1'b0;
        o_last_nxt = 1'b1;
        o_err_nxt = ERR_BAD_REF;
        state_nxt = S_OUT_WAIT;
      end else begin
        cw_en = 1'b1;
        cw_addr = in_set_index[SET_W-1:0];
        state_nxt = (in_set_index != '0) ? S_INTER_FLAG : S_NUM_NEG;
      end
    end else begin
      // Prepare a single result; taken only where a check fails or a set is empty
      o_set_nxt = cur_set_r;
      case (state_r)
        S_INTER_FLAG: begin
          if (in_acc) begin
            if (!bit_in) begin
              state_nxt = S_NUM_NEG;
            end else if (cur_set_r == num_sets_r) begin
              state_nxt = S_DELTA_IDX;
            end else begin
              ref_set_nxt = cur_set_r - 1'b1;
              state_nxt = S_SIGN;
            end
          end
        end
        S_DELTA_IDX: begin
          if (in_acc) begin
            if (g_ovf) begin
              o_err_nxt = ERR_OVERFLOW;
              state_nxt = S_OUT_WAIT;
            end else if (g_done) begin
              if (g_res >= GVAL_W'(cur_set_r)) begin
                o_err_nxt = ERR_BAD_REF;
                state_nxt = S_OUT_WAIT;
              end else begin
                ref_set_nxt = cur_set_r - 1'b1 - g_res[SET_IDX_W-1:0];
                state_nxt = S_SIGN;
              end
            end
          end
        end
        S_SIGN: begin
          if (in_acc) begin
            sign_nxt = bit_in;
            g_zeros_nxt = '0;
            g_val_nxt = '0;
            g_suf_nxt = 1'b0;
            state_nxt = S_ABS_DELTA;
          end
        end
        S_ABS_DELTA: begin
          if (in_acc) begin
            if (g_ovf || (g_done && g_res > POC_MAG_MAX)) begin
              o_err_nxt = ERR_OVERFLOW;
              state_nxt = S_OUT_WAIT;
            end else if (g_done) begin
              delta_rps_nxt = sign_r ? -(17'(g_res[POC_W-1:0]) + 17'sd1)
                                     : (17'(g_res[POC_W-1:0]) + 17'sd1);
              target_nxt = (cr_data > MAX_CNT) ? MAX_CNT : cr_data;
              loop_nxt = '0;
              state_nxt = S_USED_FLAG;
            end
          end
        end
        S_USED_FLAG, S_DELTA_FLAG: begin
          if (in_acc) begin
            if (state_r == S_USED_FLAG) begin
              sfu_nxt[loop_r] = bit_in;
            end
            if (state_r == S_USED_FLAG && !bit_in) begin
              state_nxt = S_DELTA_FLAG;
            end else begin
              sdf_nxt[loop_r] = bit_in;
              if (loop_inc > {1'b0, target_r}) begin
                state_nxt = S_DER_FIRST;
              end else begin
                loop_nxt = loop_inc[CNT_W-1:0];
                state_nxt = S_USED_FLAG;
              end
            end
          end
        end
        S_NUM_NEG: begin
          if (in_acc) begin
            if (g_ovf || (g_done && g_res > GVAL_W'(MAX_PICS))) begin
              o_err_nxt = ERR_OVERFLOW;
              state_nxt = S_OUT_WAIT;
            end else if (g_done) begin
              target_nxt = g_res[CNT_W-1:0];
              g_zeros_nxt = '0;
              g_val_nxt = '0;
              g_suf_nxt = 1'b0;
              state_nxt = S_NUM_POS;
            end
          end
        end
        S_NUM_POS: begin
          if (in_acc) begin
            if (g_ovf) begin
              o_err_nxt = ERR_OVERFLOW;
              state_nxt = S_OUT_WAIT;
            end else if (g_done && g_res != '0) begin
              o_err_nxt = ERR_POSITIVE;
              state_nxt = S_OUT_WAIT;
            end else if (g_done && target_r == '0) begin
              cw_en = 1'b1;
              o_err_nxt = ERR_NONE;
              state_nxt = S_OUT_WAIT;
            end else if (g_done) begin
              run_poc_nxt = '0;
              loop_nxt = '0;
              g_zeros_nxt = '0;
              g_val_nxt = '0;
              g_suf_nxt = 1'b0;
              state_nxt = S_POC_DELTA;
            end
          end
        end
        S_POC_DELTA: begin
          if (in_acc) begin
            if (g_ovf || (g_done && (g_res > POC_MAG_MAX || p_calc < -18'sd32768))) begin
              o_err_nxt = ERR_OVERFLOW;
              state_nxt = S_OUT_WAIT;
            end else if (g_done) begin
              run_poc_nxt = p_calc[16:0];
              state_nxt = S_POC_USED;
            end
          end
        end
        S_POC_USED: begin
          if (in_acc) begin
            tw_en = 1'b1;
            loop_nxt = loop_inc[CNT_W-1:0];
            if (loop_inc >= {1'b0, target_r}) begin
              cw_en = 1'b1;
              cw_data = target_r;
              cnt_nxt = target_r;
              idx_nxt = '0;
              state_nxt = S_EMIT_RD;
            end else begin
              g_zeros_nxt = '0;
              g_val_nxt = '0;
              g_suf_nxt = 1'b0;
              state_nxt = S_POC_DELTA;
            end
          end
        end
        S_DER_FIRST: begin
          // Own delta first when it is negative and flagged
          cnt_nxt = '0;
          idx_nxt = '0;
          tw_addr = {cur_set_r[SET_W-1:0], {PIC_W{1'b0}}};
          tw_data = {sfu_r[target_r], delta_rps_r[POC_W-1:0]};
          if (delta_rps_r < 0 && sdf_r[target_r]) begin
            tw_en = 1'b1;
            cnt_nxt = CNT_W'(1);
          end
          if (target_r == '0) begin
            cw_en = 1'b1;
            cw_data = cnt_nxt;
            if (cnt_nxt == '0) begin
              o_err_nxt = ERR_NONE;
              state_nxt = S_OUT_WAIT;
            end else begin
              state_nxt = S_EMIT_RD;
            end
          end else begin
            state_nxt = S_DER_RD;
          end
        end
        S_DER_RD: begin
          tr_addr = {ref_set_r[SET_W-1:0], idx_r[PIC_W-1:0]};
          state_nxt = S_DER_CALC;
        end
        S_DER_CALC: begin
          // Shift one reference delta and keep it if negative and flagged
          tw_addr = {cur_set_r[SET_W-1:0], cnt_r[PIC_W-1:0]};
          tw_data = {sfu_r[idx_r], d_calc[POC_W-1:0]};
          if (d_calc < 0 && sdf_r[idx_r] &&
              (d_calc < -18'sd32768 || cnt_r >= MAX_CNT)) begin
            o_err_nxt = ERR_OVERFLOW;
            state_nxt = S_OUT_WAIT;
          end else begin
            if (d_calc < 0 && sdf_r[idx_r]) begin
              tw_en = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end
            idx_nxt = idx_r + 1'b1;
            if (idx_r + 1'b1 == target_r) begin
              cw_en = 1'b1;
              cw_data = cnt_nxt;
              idx_nxt = '0;
              if (cnt_nxt == '0) begin
                o_err_nxt = ERR_NONE;
                state_nxt = S_OUT_WAIT;
              end else begin
                state_nxt = S_EMIT_RD;
              end
            end else begin
              state_nxt = S_DER_RD;
            end
          end
        end
        S_EMIT_RD: begin
          state_nxt = S_EMIT_LD;
        end
        S_EMIT_LD: begin
          out_valid_nxt = 1'b1;
          o_idx_nxt = ENTRY_W'(idx_r[PIC_W-1:0]);
          o_poc_nxt = tr_data[POC_W-1:0];
          o_used_nxt = tr_data[POC_W];
          o_ev_nxt = 1'b1;
          o_err_nxt = ERR_NONE;
          o_last_nxt = (idx_r + 1'b1 == cnt_r);
          state_nxt = S_EMIT_HOLD;
        end
        S_EMIT_HOLD: begin
          if (out_ready) begin
            out_valid_nxt = 1'b0;
            idx_nxt = idx_r + 1'b1;
            state_nxt = o_last_r ? S_IDLE : S_EMIT_RD;
          end
        end
        S_OUT_WAIT: begin
          if (out_valid_r && out_ready) begin
            out_valid_nxt = 1'b0;
            state_nxt = S_IDLE;
          end
        end
        default: begin
          state_nxt = state_r;
        end
      endcase

      // Single result: error or empty set; clear the set's count
      if (state_r != S_OUT_WAIT && state_nxt == S_OUT_WAIT) begin
        cw_en = 1'b1;
        cw_data = '0;
        out_valid_nxt = 1'b1;
        o_idx_nxt = '0;
        o_poc_nxt = '0;
        o_used_nxt = 1'b0;
        o_ev_nxt = 1'b0;
        o_last_nxt = 1'b1;
      end
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      num_sets_r <= '0;
      out_valid_r <= 1'b0;
      g_zeros_r <= '0;
      g_val_r <= '0;
      g_suf_r <= 1'b0;
      run_poc_r <= '0;
      delta_rps_r <= '0;
      loop_r <= '0;
      sfu_r <= '0;
      sdf_r <= '0;
      cur_set_r <= '0;
      ref_set_r <= '0;
      target_r <= '0;
      cnt_r <= '0;
      idx_r <= '0;
      sign_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        num_sets_r <= cfg_data;
      end
      out_valid_r <= out_valid_nxt;
      g_zeros_r <= g_zeros_nxt;
      g_val_r <= g_val_nxt;
      g_suf_r <= g_suf_nxt;
      run_poc_r <= run_poc_nxt;
      delta_rps_r <= delta_rps_nxt;
      loop_r <= loop_nxt;
      sfu_r <= sfu_nxt;
      sdf_r <= sdf_nxt;
      cur_set_r <= cur_set_nxt;
      ref_set_r <= ref_set_nxt;
      target_r <= target_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      sign_r <= sign_nxt;
    end
    o_set_r <= o_set_nxt;
    o_idx_r <= o_idx_nxt;
    o_poc_r <= o_poc_nxt;
    o_used_r <= o_used_nxt;
    o_ev_r <= o_ev_nxt;
    o_last_r <= o_last_nxt;
    o_err_r <= o_err_nxt;
  end

  // Accept input only in parse phases
  assign in_ready = (state_r == S_IDLE) || (state_r == S_INTER_FLAG) ||
                    (state_r == S_DELTA_IDX) || (state_r == S_SIGN) ||
                    (state_r == S_ABS_DELTA) || (state_r == S_USED_FLAG) ||
                    (state_r == S_DELTA_FLAG) || (state_r == S_NUM_NEG) ||
                    (state_r == S_NUM_POS) || (state_r == S_POC_DELTA) ||
                    (state_r == S_POC_USED);

  assign out_valid = out_valid_r;
  assign out_out_set = o_set_r;
  assign out_entry_index = o_idx_r;
  assign out_delta_poc = signed'(o_poc_r);
  assign out_used_by_current = o_used_r;
  assign out_entry_valid = o_ev_r;
  assign out_error_code = o_err_r;
  assign out_last = o_last_r;

endmodule

// ----- src/strps_checker.sv -----
// Port-level checker for the parser, bound to the top level.
module strps_checker
  import strps_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_entry_valid,
  input logic [1:0] out_error_code,
  input logic       out_last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Take no transaction while a result is pending
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // Reset clears the result channel
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Empty or error results close their set
  a_invalid_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_valid |-> out_last)
    else $error("invalid entry not marked last");

  // Errors never carry an entry
  a_err_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_NONE |-> !out_entry_valid)
    else $error("error result marked valid");

endmodule

bind short_term_ref_pic_set_parser strps_checker u_strps_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_entry_valid(out_entry_valid),
  .out_error_code(out_error_code),
  .out_last(out_last)
);

// ----- tb/tb_short_term_ref_pic_set_parser.sv -----
// Self-checking testbench for the short-term reference picture set parser.
module tb_short_term_ref_pic_set_parser;
  import strps_pkg::*;

  localparam int NUM_ROWS    = 65;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 80;

  // Parse phases of the local decoder
  typedef enum {
    P_IDLE, P_INTER, P_DIDX, P_SIGN, P_ABS, P_USED, P_DFLAG,
    P_NNEG, P_NPOS, P_PDELTA, P_PUSED
  } parse_phase_t;

  typedef struct {
    logic [SET_IDX_W-1:0] set_id;
    logic [ENTRY_W-1:0]   entry;
    logic [POC_W-1:0]     poc;
    logic                 used;
    logic                 valid;
    err_code_t            err;
    logic                 last;
  } rps_entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [SET_IDX_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_opcode = OP_START;
  logic [SET_IDX_W-1:0] in_set_index = '0;
  logic in_bit_value = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SET_IDX_W-1:0] out_out_set;
  logic [ENTRY_W-1:0] out_entry_index;
  logic signed [POC_W-1:0] out_delta_poc;
  logic out_used_by_current;
  logic out_entry_valid;
  logic [1:0] out_error_code;
  logic out_last;

  short_term_ref_pic_set_parser uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_set_index(in_set_index), .in_bit_value(in_bit_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_out_set(out_out_set),
    .out_entry_index(out_entry_index), .out_delta_poc(out_delta_poc),
    .out_used_by_current(out_used_by_current), .out_entry_valid(out_entry_valid),
    .out_error_code(out_error_code), .out_last(out_last)
  );

  always #2 clk = ~clk;

  // Predictor state
  logic [POC_W-1:0] poc_rows [0:NUM_ROWS-1][0:15];
  logic             used_rows[0:NUM_ROWS-1][0:15];
  int               row_count[0:NUM_ROWS-1];
  logic             used_flags[0:16];
  logic             delta_flags[0:16];
  parse_phase_t     phase = P_IDLE;
  int               g_zeros;
  longint           g_val;
  bit               g_suffix;
  int               run_poc;
  int               delta_rps;
  int               loop_n;
  int               num_sets_cfg;
  int               cur_set;
  int               ref_row;
  int               target_n;
  bit               neg_sign;

  rps_entry_t expected_entries[$];
  int  fail_count = 0;
  int  cycles = 0;
  int  items_sent = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;

  function automatic void push_entry(int entry, int poc, bit used, bit valid,
                                     err_code_t err, bit last);
    rps_entry_t e;
    e.set_id = cur_set[SET_IDX_W-1:0];
    e.entry  = entry[ENTRY_W-1:0];
    e.poc    = poc[POC_W-1:0];
    e.used   = used;
    e.valid  = valid;
    e.err    = err;
    e.last   = last;
    expected_entries.push_back(e);
  endfunction

  function automatic void fail_set(err_code_t code);
    if (cur_set < NUM_ROWS) row_count[cur_set] = 0;
    phase = P_IDLE;
    push_entry(0, 0, 0, 0, code, 1);
  endfunction

  function automatic void finish_set(int count);
    row_count[cur_set] = count;
    phase = P_IDLE;
    if (count == 0) begin
      push_entry(0, 0, 0, 0, ERR_NONE, 1);
      return;
    end
    for (int i = 0; i < count; i++)
      push_entry(i, int'($signed(poc_rows[cur_set][i])), used_rows[cur_set][i],
                 1, ERR_NONE, i + 1 == count);
  endfunction

  function automatic void golomb_begin(parse_phase_t p);
    g_zeros = 0;
    g_val = 0;
    g_suffix = 0;
    phase = p;
  endfunction

  // Advance the Exp-Golomb decoder: 0 pending, 1 value ready, -1 overflow
  function automatic int golomb_step(bit b);
    if (!g_suffix) begin
      if (!b) begin
        g_zeros++;
        return (g_zeros > 32) ? -1 : 0;
      end
      if (g_zeros == 0) begin
        g_val = 0;
        return 1;
      end
      g_val = 1;
      g_suffix = 1;
      return 0;
    end
    g_val = (g_val << 1) | b;
    g_zeros--;
    if (g_zeros == 0) begin
      g_val -= 1;
      g_suffix = 0;
      return 1;
    end
    return 0;
  endfunction

  // Build the inter-predicted set from the reference row
  function automatic void derive_set();
    int n, i, d;
    n = target_n;
    i = 0;
    if (delta_rps < 0 && delta_flags[n]) begin
      poc_rows[cur_set][i] = delta_rps[POC_W-1:0];
      used_rows[cur_set][i] = used_flags[n];
      i++;
    end
    for (int j = 0; j < n; j++) begin
      d = int'($signed(poc_rows[ref_row][j])) + delta_rps;
      if (d < 0 && delta_flags[j]) begin
        if (d < -32768 || i >= 16) begin
          fail_set(ERR_OVERFLOW);
          return;
        end
        poc_rows[cur_set][i] = d[POC_W-1:0];
        used_rows[cur_set][i] = used_flags[j];
        i++;
      end
    end
    finish_set(i);
  endfunction

  function automatic void next_flag();
    loop_n++;
    if (loop_n > target_n) derive_set();
    else phase = P_USED;
  endfunction

  // Work out the results of one accepted transaction
  function automatic void predict_rps(logic op, int idx, bit b);
    int g;
    longint p;
    if (op == OP_START) begin
      cur_set = idx;
      if (cur_set > 64) begin
        fail_set(ERR_BAD_REF);
        return;
      end
      row_count[cur_set] = 0;
      if (cur_set != 0) phase = P_INTER;
      else golomb_begin(P_NNEG);
      return;
    end
    case (phase)
      P_INTER: begin
        if (!b) golomb_begin(P_NNEG);
        else if (cur_set == num_sets_cfg) golomb_begin(P_DIDX);
        else begin
          ref_row = cur_set - 1;
          phase = P_SIGN;
        end
      end
      P_DIDX: begin
        g = golomb_step(b);
        if (g < 0) fail_set(ERR_OVERFLOW);
        else if (g > 0) begin
          if (g_val >= cur_set) fail_set(ERR_BAD_REF);
          else begin
            ref_row = cur_set - 1 - int'(g_val);
            phase = P_SIGN;
          end
        end
      end
      P_SIGN: begin
        neg_sign = b;
        golomb_begin(P_ABS);
      end
      P_ABS: begin
        g = golomb_step(b);
        if (g < 0) fail_set(ERR_OVERFLOW);
        else if (g > 0) begin
          if (g_val > 32767) fail_set(ERR_OVERFLOW);
          else begin
            delta_rps = int'(g_val) + 1;
            if (neg_sign) delta_rps = -delta_rps;
            target_n = row_count[ref_row] & 5'h1f;
            if (target_n > 16) target_n = 16;
            loop_n = 0;
            phase = P_USED;
          end
        end
      end
      P_USED: begin
        used_flags[loop_n] = b;
        if (b) begin
          delta_flags[loop_n] = 1;
          next_flag();
        end else phase = P_DFLAG;
      end
      P_DFLAG: begin
        delta_flags[loop_n] = b;
        next_flag();
      end
      P_NNEG: begin
        g = golomb_step(b);
        if (g < 0) fail_set(ERR_OVERFLOW);
        else if (g > 0) begin
          if (g_val > 16) fail_set(ERR_OVERFLOW);
          else begin
            target_n = int'(g_val);
            golomb_begin(P_NPOS);
          end
        end
      end
      P_NPOS: begin
        g = golomb_step(b);
        if (g < 0) fail_set(ERR_OVERFLOW);
        else if (g > 0) begin
          if (g_val != 0) fail_set(ERR_POSITIVE);
          else if (target_n == 0) finish_set(0);
          else begin
            run_poc = 0;
            loop_n = 0;
            golomb_begin(P_PDELTA);
          end
        end
      end
      P_PDELTA: begin
        g = golomb_step(b);
        if (g < 0) fail_set(ERR_OVERFLOW);
        else if (g > 0) begin
          p = longint'(run_poc) - g_val - 1;
          if (p < -32768) fail_set(ERR_OVERFLOW);
          else begin
            run_poc = int'(p);
            poc_rows[cur_set][loop_n & 15] = run_poc[POC_W-1:0];
            phase = P_PUSED;
          end
        end
      end
      P_PUSED: begin
        used_rows[cur_set][loop_n & 15] = b;
        loop_n++;
        if (loop_n >= target_n) finish_set(target_n);
        else golomb_begin(P_PDELTA);
      end
      default: ;
    endcase
  endfunction

  // Send one transaction, at times with a random gap ahead of it outside steady phases
  task automatic send_item(logic op, int idx, bit b);
    if (!tx_steady && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_set_index <= (op == OP_START) ? idx[SET_IDX_W-1:0] : SET_IDX_W'($urandom);
    in_bit_value <= (op == OP_BIT) ? b : 1'($urandom);
    do @(posedge clk); while (!in_ready);
    items_sent++;
    predict_rps(op, idx, b);
  endtask

  task automatic send_bit(bit b);
    send_item(OP_BIT, 0, b);
  endtask

  // Unsigned Exp-Golomb code, most significant bit first
  task automatic send_ue(longint v);
    longint m;
    int nb;
    m = v + 1;
    nb = 0;
    for (longint t = m; t != 0; t >>= 1) nb++;
    repeat (nb - 1) send_bit(0);
    for (int k = nb - 1; k >= 0; k--) send_bit(m[k]);
  endtask

  // Hold input low until every expected result is out, then settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_num_sets(int v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_data <= v[SET_IDX_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    num_sets_cfg = v;
  endtask

  // Explicit set: nneg deltas of at most max_step+1 each
  task automatic send_explicit(int idx, int nneg, int npos, int max_step);
    send_item(OP_START, idx, 0);
    if (idx != 0) send_bit(0);
    send_ue(nneg);
    send_ue(npos);
    if (nneg > 16 || npos != 0) return;
    for (int i = 0; i < nneg; i++) begin
      send_ue($urandom_range(max_step));
      send_bit($urandom_range(1));
    end
  endtask

  // Inter-predicted set; flags follow the decoder's own loop
  task automatic send_inter(int idx, int didx, bit sgn, longint absm1, bit all_used);
    send_item(OP_START, idx, 0);
    send_bit(1);
    if (idx == num_sets_cfg) send_ue(didx);
    if (phase != P_SIGN) return;
    send_bit(sgn);
    send_ue(absm1);
    while (phase == P_USED || phase == P_DFLAG)
      send_bit(all_used ? 1'b1 : 1'($urandom_range(1)));
  endtask

  // Start every row once so that each set count is defined
  task automatic test_row_init();
    for (int i = 0; i <= 64; i++) send_item(OP_START, i, 0);
    send_explicit(0, 0, 0, 0);
  endtask

  task automatic test_explicit_extremes();
    send_bit(1);
    send_bit(0);
    send_explicit(0, 16, 0, 0);
    send_explicit(1, 2, 0, 32767);
    send_explicit(2, 2, 0, 0);
    send_explicit(3, 17, 0, 0);
    send_explicit(4, 0, 1, 0);
    send_item(OP_START, 5, 0);
    send_bit(0);
    repeat (33) send_bit(0);
  endtask

  task automatic test_inter_prediction();
    send_explicit(9, 16, 0, 0);
    send_inter(10, 0, 1, 0, 1'b1);
    send_inter(11, 0, 0, 4, 1'b0);
    send_inter(12, 0, 1, 32767, 1'b0);
    send_inter(13, 0, 1, 32768, 1'b0);
    send_explicit(14, 0, 0, 0);
    send_inter(15, 0, 1, 2, 1'b1);
  endtask

  task automatic test_slice_header_set();
    write_num_sets(20);
    send_explicit(18, 4, 0, 5);
    send_inter(20, 1, 1, 1, 1'b0);
    send_inter(20, 20, 0, 0, 1'b0);
    send_inter(20, 19, 1, 0, 1'b1);
    send_item(OP_START, 127, 0);
    send_item(OP_START, 64, 0);
  endtask

  task automatic test_random(int cfg_value, int count);
    int start_items, idx, r;
    write_num_sets(cfg_value);
    start_items = items_sent;
    while (items_sent - start_items < count) begin
      tx_steady = (items_sent - start_items) > count / 4 &&
                  (items_sent - start_items) < (3 * count) / 4;
      rx_steady = tx_steady;
      r = $urandom_range(99);
      idx = $urandom_range(64);
      if (r < 40) begin
        send_explicit(idx, ($urandom_range(19) == 0) ? 17 : $urandom_range(6),
                      ($urandom_range(19) == 0) ? $urandom_range(1, 3) : 0,
                      ($urandom_range(9) == 0) ? 30000 : 5);
      end else if (r < 80) begin
        if (idx == 0) idx = 1;
        if ($urandom_range(3) == 0 && num_sets_cfg > 0) idx = num_sets_cfg;
        send_inter(idx, $urandom_range(idx), $urandom_range(1),
                   ($urandom_range(19) == 0) ? 32768 : $urandom_range(6),
                   $urandom_range(7) == 0);
      end else if (r < 88) begin
        send_item(OP_START, $urandom_range(127), 0);
      end else begin
        repeat ($urandom_range(1, 8)) send_bit($urandom_range(1));
      end
    end
    tx_steady = 0;
    rx_steady = 0;
  endtask

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Compare each result with the oldest expectation; randomize output stall
  always @(posedge clk) begin : result_check
    rps_entry_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_entries.size() == 0) begin
        $error("unexpected result for set %0d", out_out_set);
        fail_count++;
      end else begin
        e = expected_entries.pop_front();
        check_field("out_set", e.set_id, out_out_set);
        check_field("entry_index", e.entry, out_entry_index);
        check_field("delta_poc", $signed(e.poc), out_delta_poc);
        check_field("used_by_current", e.used, out_used_by_current);
        check_field("entry_valid", e.valid, out_entry_valid);
        check_field("error_code", e.err, out_error_code);
        check_field("last", e.last, out_last);
      end
    end
    out_ready <= rx_steady || ($urandom_range(99) >= 30);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i <= 16; i++) begin
      used_flags[i] = 0;
      delta_flags[i] = 0;
    end
    num_sets_cfg = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_row_init();
    test_explicit_extremes();
    test_inter_prediction();
    test_slice_header_set();
    test_random(64, 30);
    test_random($urandom_range(1, 63), 30);
    test_random(0, 20);
    drain_results();
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
